// ===== sv/sjf_pkg.sv =====
// Shared types and constants for the SJF scheduler block.
// No dependencies; used by sjf_job_store, sjf_divider and the top level.
package sjf_pkg;

  localparam int MAX_JOBS = 16;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 16;
  localparam int CLK_W    = 21;
  localparam int SUM_W    = 25;
  localparam int AVG_W    = 29;
  localparam int Q_FRAC   = 8;
  localparam int NUM_W    = SUM_W + Q_FRAC;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int STEP_W   = $clog2(NUM_W + 1);

  localparam logic [CLK_W-1:0] CLK_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [CNT_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/sjf_job_store.sv =====
// Job table: one write port at load time, one registered read port for the scans.
// Depends on sjf_pkg (job_t, MAX_JOBS, IDX_W).
module sjf_job_store (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [sjf_pkg::IDX_W-1:0] wr_addr,
  input  sjf_pkg::job_t            wr_data,
  input  logic [sjf_pkg::IDX_W-1:0] rd_addr,
  output sjf_pkg::job_t            rd_data
);

  sjf_pkg::job_t mem_r [sjf_pkg::MAX_JOBS];
  sjf_pkg::job_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data is registered, so it lands in the cycle after the address; a write to
  // the same slot in that cycle is forwarded
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/sjf_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the Q8 averages.
// Depends on sjf_pkg (div_req_t, div_rsp_t, widths).
module sjf_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  sjf_pkg::div_req_t   req,
  output sjf_pkg::div_rsp_t   rsp
);

  logic                        busy_r;
  logic                        done_r;
  logic [sjf_pkg::STEP_W-1:0]  step_r;
  logic [sjf_pkg::NUM_W-1:0]   num_r;
  logic [sjf_pkg::NUM_W-1:0]   quot_r;
  logic [sjf_pkg::CNT_W-1:0]   rem_r;
  logic [sjf_pkg::CNT_W-1:0]   den_r;

  logic [sjf_pkg::CNT_W:0]     trial;
  logic [sjf_pkg::CNT_W:0]     diff;
  logic                        ge;
  logic [sjf_pkg::CNT_W-1:0]   rem_step;

  always_comb begin
    trial    = {rem_r, num_r[sjf_pkg::NUM_W-1]};
    ge       = trial >= {1'b0, den_r};
    diff     = trial - {1'b0, den_r};
    rem_step = ge ? diff[sjf_pkg::CNT_W-1:0] : trial[sjf_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + sjf_pkg::STEP_W'(1);
        if (step_r == sjf_pkg::STEP_W'(sjf_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      num_r  <= req.numer;
      den_r  <= req.denom;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_step;
      num_r  <= {num_r[sjf_pkg::NUM_W-2:0], 1'b0};
      quot_r <= {quot_r[sjf_pkg::NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== sv/sjf_nonpreemptive_scheduler_unit.sv =====
// Top level of the non-preemptive shortest-job-first scheduler.
// Depends on sjf_pkg, sjf_job_store and sjf_divider.
//
//  channel | ports                               | direction
//  --------+-------------------------------------+-----------
//  in      | in_valid/in_ready + job word        | to block
//  out     | out_valid/out_ready + result word   | from block
//
// Schedule: a word without last_job is stored when it is accepted. The last word starts
//   the schedule: each completion costs two scans of the job table through one
//   compare unit, then the retire and accumulate states and the emit state; the final
//   result first takes two divider runs, for the wait and turnaround averages.
// Reset: rst_n is synchronous, active low; clears the batch and the handshakes.
// Stalls: in_ready is high only while loading; during scheduling the block
//   holds each result word until out_ready takes it.
module sjf_nonpreemptive_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // job input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sjf_pkg::ID_W-1:0]    in_job_id,
  input  logic [sjf_pkg::TIME_W-1:0]  in_arrival_time,
  input  logic [sjf_pkg::TIME_W-1:0]  in_burst_time,
  input  logic                        in_last_job,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sjf_pkg::ID_W-1:0]    out_job_id_res,
  output logic [sjf_pkg::TIME_W-1:0]  out_arrival_time_res,
  output logic [sjf_pkg::TIME_W-1:0]  out_burst_time_res,
  output logic [sjf_pkg::CLK_W-1:0]   out_wait_time,
  output logic [sjf_pkg::CLK_W-1:0]   out_turnaround_time,
  output logic [sjf_pkg::AVG_W-1:0]   out_avg_wait_q8,
  output logic [sjf_pkg::AVG_W-1:0]   out_avg_turnaround_q8,
  output logic                        out_overflow,
  output logic                        out_last_result
);

  // sequencer states
  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_SCAN_ARR  = 4'd1;  // earliest pending arrival
  localparam logic [3:0] S_SCAN_BEST = 4'd2;  // shortest ready burst
  localparam logic [3:0] S_RUN       = 4'd3;  // retire picked job, advance clock
  localparam logic [3:0] S_ACC_W     = 4'd4;  // turnaround, wait sum
  localparam logic [3:0] S_ACC_T     = 4'd5;  // turnaround sum
  localparam logic [3:0] S_DIV_W_GO  = 4'd6;
  localparam logic [3:0] S_DIV_W     = 4'd7;
  localparam logic [3:0] S_DIV_T_GO  = 4'd8;
  localparam logic [3:0] S_DIV_T     = 4'd9;
  localparam logic [3:0] S_EMIT      = 4'd10;

  logic [3:0]                    state_r,    state_nxt;
  logic [sjf_pkg::CNT_W-1:0]     count_r,    count_nxt;
  logic [sjf_pkg::CNT_W-1:0]     k_r,        k_nxt;
  logic                          ovf_r,      ovf_nxt;
  logic [sjf_pkg::MAX_JOBS-1:0]  done_r,     done_nxt;
  logic [sjf_pkg::IDX_W-1:0]     idx_r,      idx_nxt;
  logic [sjf_pkg::CLK_W-1:0]     clock_r,    clock_nxt;
  logic [sjf_pkg::SUM_W-1:0]     wsum_r,     wsum_nxt;
  logic [sjf_pkg::SUM_W-1:0]     tsum_r,     tsum_nxt;
  logic [sjf_pkg::TIME_W-1:0]    earliest_r, earliest_nxt;
  logic                          found_r,    found_nxt;
  logic [sjf_pkg::IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [sjf_pkg::TIME_W-1:0]    best_b_r,   best_b_nxt;
  logic [sjf_pkg::TIME_W-1:0]    best_a_r,   best_a_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // result word
  logic [sjf_pkg::ID_W-1:0]      o_id_r,    o_id_nxt;
  logic [sjf_pkg::TIME_W-1:0]    o_arr_r,   o_arr_nxt;
  logic [sjf_pkg::TIME_W-1:0]    o_burst_r, o_burst_nxt;
  logic [sjf_pkg::CLK_W-1:0]     o_wait_r,  o_wait_nxt;
  logic [sjf_pkg::CLK_W-1:0]     o_tat_r,   o_tat_nxt;
  logic [sjf_pkg::AVG_W-1:0]     o_avgw_r,  o_avgw_nxt;
  logic [sjf_pkg::AVG_W-1:0]     o_avgt_r,  o_avgt_nxt;
  logic                          o_ovf_r,   o_ovf_nxt;
  logic                          o_last_r,  o_last_nxt;

  // job table
  logic                          wr_en;
  sjf_pkg::job_t                 wr_data;
  logic [sjf_pkg::IDX_W-1:0]     rd_addr;
  sjf_pkg::job_t                 rd_data;

  // divider
  sjf_pkg::div_req_t             div_req;
  sjf_pkg::div_rsp_t             div_rsp;
  logic [sjf_pkg::AVG_W-1:0]     quot_sat;

  // scan helpers
  logic                          last_idx;
  logic [sjf_pkg::TIME_W-1:0]    cand_arr;
  logic                          eligible;
  logic                          better;
  logic [sjf_pkg::CLK_W:0]       clk_sum;
  logic [sjf_pkg::SUM_W:0]       acc_sum;

  sjf_job_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[sjf_pkg::IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sjf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign wr_data.id      = in_job_id;
  assign wr_data.arrival = in_arrival_time;
  assign wr_data.burst   = in_burst_time;

  // table read is registered, so the address is taken from the next-state values: the next
  // scan slot, or the picked slot when the retire step comes next
  assign rd_addr = (state_nxt == S_RUN) ? best_idx_nxt : idx_nxt;

  assign in_ready = (state_r == S_LOAD);

  assign div_req.start = (state_r == S_DIV_W_GO) || (state_r == S_DIV_T_GO);
  assign div_req.numer = (state_r == S_DIV_T_GO) ? {tsum_r, {sjf_pkg::Q_FRAC{1'b0}}}
                                                 : {wsum_r, {sjf_pkg::Q_FRAC{1'b0}}};
  assign div_req.denom = count_r;

  // averages saturate at the field width
  assign quot_sat = (div_rsp.quot[sjf_pkg::NUM_W-1:sjf_pkg::AVG_W] != '0)
                  ? sjf_pkg::AVG_MAX : div_rsp.quot[sjf_pkg::AVG_W-1:0];

  assign last_idx = (sjf_pkg::CNT_W'(idx_r) + sjf_pkg::CNT_W'(1)) == count_r;

  always_comb begin
    // earliest arrival among unfinished jobs, running min
    cand_arr = (!done_r[idx_r] && rd_data.arrival < earliest_r) ? rd_data.arrival
                                                               : earliest_r;
    // ready and unfinished; shortest burst, then earlier arrival, then lower slot
    eligible = !done_r[idx_r]
            && ({{(sjf_pkg::CLK_W-sjf_pkg::TIME_W){1'b0}}, rd_data.arrival} <= clock_r);
    better   = !found_r
            || (rd_data.burst < best_b_r)
            || (rd_data.burst == best_b_r && rd_data.arrival < best_a_r);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    ovf_nxt       = ovf_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    clock_nxt     = clock_r;
    wsum_nxt      = wsum_r;
    tsum_nxt      = tsum_r;
    earliest_nxt  = earliest_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_b_nxt    = best_b_r;
    best_a_nxt    = best_a_r;
    out_valid_nxt = out_valid_r;
    o_id_nxt      = o_id_r;
    o_arr_nxt     = o_arr_r;
    o_burst_nxt   = o_burst_r;
    o_wait_nxt    = o_wait_r;
    o_tat_nxt     = o_tat_r;
    o_avgw_nxt    = o_avgw_r;
    o_avgt_nxt    = o_avgt_r;
    o_ovf_nxt     = o_ovf_r;
    o_last_nxt    = o_last_r;
    wr_en         = 1'b0;
    clk_sum       = '0;
    acc_sum       = '0;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (count_r < sjf_pkg::CNT_W'(sjf_pkg::MAX_JOBS)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + sjf_pkg::CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;  // batch full, job dropped
          end
          if (in_last_job) begin
            idx_nxt      = '0;
            earliest_nxt = '1;
            k_nxt        = '0;
            state_nxt    = S_SCAN_ARR;
          end
        end
      end

      S_SCAN_ARR: begin
        earliest_nxt = cand_arr;
        idx_nxt      = idx_r + sjf_pkg::IDX_W'(1);
        if (last_idx) begin
          // idle gap: jump the clock to the next arrival
          if ({{(sjf_pkg::CLK_W-sjf_pkg::TIME_W){1'b0}}, cand_arr} > clock_r) begin
            clock_nxt = {{(sjf_pkg::CLK_W-sjf_pkg::TIME_W){1'b0}}, cand_arr};
          end
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN_BEST;
        end
      end

      S_SCAN_BEST: begin
        if (eligible && better) begin
          found_nxt    = 1'b1;
          best_idx_nxt = idx_r;
          best_b_nxt   = rd_data.burst;
          best_a_nxt   = rd_data.arrival;
        end
        idx_nxt = idx_r + sjf_pkg::IDX_W'(1);
        if (last_idx) begin
          state_nxt = S_RUN;
        end
      end

      S_RUN: begin
        done_nxt[best_idx_r] = 1'b1;
        o_id_nxt    = rd_data.id;
        o_arr_nxt   = rd_data.arrival;
        o_burst_nxt = rd_data.burst;
        o_wait_nxt  = clock_r - {{(sjf_pkg::CLK_W-sjf_pkg::TIME_W){1'b0}}, rd_data.arrival};
        clk_sum     = {1'b0, clock_r}
                    + {{(sjf_pkg::CLK_W+1-sjf_pkg::TIME_W){1'b0}}, rd_data.burst};
        clock_nxt   = clk_sum[sjf_pkg::CLK_W] ? sjf_pkg::CLK_MAX
                                              : clk_sum[sjf_pkg::CLK_W-1:0];
        k_nxt       = k_r + sjf_pkg::CNT_W'(1);
        state_nxt   = S_ACC_W;
      end

      S_ACC_W: begin
        o_tat_nxt = clock_r - {{(sjf_pkg::CLK_W-sjf_pkg::TIME_W){1'b0}}, o_arr_r};
        acc_sum   = {1'b0, wsum_r} + {{(sjf_pkg::SUM_W+1-sjf_pkg::CLK_W){1'b0}}, o_wait_r};
        wsum_nxt  = acc_sum[sjf_pkg::SUM_W] ? sjf_pkg::SUM_MAX
                                            : acc_sum[sjf_pkg::SUM_W-1:0];
        state_nxt = S_ACC_T;
      end

      S_ACC_T: begin
        acc_sum    = {1'b0, tsum_r} + {{(sjf_pkg::SUM_W+1-sjf_pkg::CLK_W){1'b0}}, o_tat_r};
        tsum_nxt   = acc_sum[sjf_pkg::SUM_W] ? sjf_pkg::SUM_MAX
                                             : acc_sum[sjf_pkg::SUM_W-1:0];
        o_ovf_nxt  = ovf_r;
        o_avgw_nxt = '0;
        o_avgt_nxt = '0;
        o_last_nxt = 1'b0;
        if (k_r == count_r) begin
          state_nxt = S_DIV_W_GO;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end
      end

      S_DIV_W_GO: begin
        state_nxt = S_DIV_W;
      end

      S_DIV_W: begin
        if (div_rsp.done) begin
          o_avgw_nxt = quot_sat;
          state_nxt  = S_DIV_T_GO;
        end
      end

      S_DIV_T_GO: begin
        state_nxt = S_DIV_T;
      end

      S_DIV_T: begin
        if (div_rsp.done) begin
          o_avgt_nxt    = quot_sat;
          o_last_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (o_last_r) begin
            // batch finished: back to an empty table
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            done_nxt  = '0;
            clock_nxt = '0;
            wsum_nxt  = '0;
            tsum_nxt  = '0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt      = '0;
            earliest_nxt = '1;
            state_nxt    = S_SCAN_ARR;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      k_r         <= '0;
      ovf_r       <= 1'b0;
      done_r      <= '0;
      clock_r     <= '0;
      wsum_r      <= '0;
      tsum_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      ovf_r       <= ovf_nxt;
      done_r      <= done_nxt;
      clock_r     <= clock_nxt;
      wsum_r      <= wsum_nxt;
      tsum_r      <= tsum_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    earliest_r <= earliest_nxt;
    best_idx_r <= best_idx_nxt;
    best_b_r   <= best_b_nxt;
    best_a_r   <= best_a_nxt;
    o_id_r     <= o_id_nxt;
    o_arr_r    <= o_arr_nxt;
    o_burst_r  <= o_burst_nxt;
    o_wait_r   <= o_wait_nxt;
    o_tat_r    <= o_tat_nxt;
    o_avgw_r   <= o_avgw_nxt;
    o_avgt_r   <= o_avgt_nxt;
    o_ovf_r    <= o_ovf_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_job_id_res        = o_id_r;
  assign out_arrival_time_res  = o_arr_r;
  assign out_burst_time_res    = o_burst_r;
  assign out_wait_time         = o_wait_r;
  assign out_turnaround_time   = o_tat_r;
  assign out_avg_wait_q8       = o_avgw_r;
  assign out_avg_turnaround_q8 = o_avgt_r;
  assign out_overflow          = o_ovf_r;
  assign out_last_result       = o_last_r;

`ifndef SYNTH
  // loading and emitting never overlap
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("in_ready while a result word is pending");

  // averages only ride on the final result
  a_avg_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |->
      (out_avg_wait_q8 == '0 && out_avg_turnaround_q8 == '0))
    else $error("nonzero average on a non-final result");

  // completion never precedes start
  a_tat_ge_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_turnaround_time >= out_wait_time))
    else $error("turnaround below wait");

  // a last job starts scheduling and closes the input
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_job) |=> !in_ready)
    else $error("input still open after last job");
`endif

endmodule
